>>> hdl/tcp_keyword_packet_detector_unit_defines.svh
// Assertion macros used by the keyword packet detector top level.
// Depends on nothing; each macro expects signals clk and rst_n in scope.
`ifndef TCP_KEYWORD_PACKET_DETECTOR_UNIT_DEFINES_SVH
`define TCP_KEYWORD_PACKET_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TKPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TKPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tkpd_pkg.sv
// Package for the TCP keyword packet detector: transaction types, constants
// and the status structs passed between its modules. Depends on nothing.
package tkpd_pkg;

    // Frame geometry and header codes.
    localparam logic [15:0] MAX_FRAME_BYTES  = 16'd16383;
    localparam logic [15:0] MIN_FRAME_LAST   = 16'd53;
    localparam logic [15:0] POS_ETYPE_HI     = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO     = 16'd13;
    localparam logic [15:0] POS_VLAN_HI      = 16'd16;
    localparam logic [15:0] POS_VLAN_LO      = 16'd17;
    localparam logic [7:0]  ETH_HDR_BYTES    = 8'd14;
    localparam logic [7:0]  ETH_VLAN_BYTES   = 8'd18;
    localparam logic [15:0] ETYPE_VLAN       = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP     = 8'd6;
    localparam logic [5:0]  MIN_HDR_BYTES    = 6'd20;
    localparam logic [15:0] IP_OFF_PROTO     = 16'd9;
    localparam logic [15:0] IP_OFF_SRC_FIRST = 16'd12;
    localparam logic [15:0] IP_OFF_SRC_LAST  = 16'd15;
    localparam logic [15:0] IP_OFF_DST_FIRST = 16'd16;
    localparam logic [15:0] IP_OFF_DST_LAST  = 16'd19;
    localparam logic [15:0] TCP_OFF_SPORT_LAST = 16'd1;
    localparam logic [15:0] TCP_OFF_DPORT_LAST = 16'd3;
    localparam logic [15:0] TCP_OFF_DOFF     = 16'd12;
    localparam logic [15:0] TCP_OFF_FLAGS    = 16'd13;
    localparam int unsigned TCP_PSH_BIT      = 3;

    // Keywords, last byte lowest.
    localparam logic [31:0] KW_BLOB   = 32'h626C6F62;
    localparam logic [39:0] KW_NONCE  = 40'h6E6F6E6365;
    localparam logic [47:0] KW_MINING = 48'h6D696E696E67;

    // Input transaction.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } tkpd_frame_t;

    // Output transaction.
    typedef struct packed {
        logic        detected;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } tkpd_result_t;

    // One byte moving from the input register into the frame state.
    typedef struct packed {
        logic        advance;
        logic        last;
        logic        inspect;
        logic [15:0] position;
        logic [7:0]  data;
    } tkpd_step_t;

    // Header state after the current byte has been applied.
    typedef struct packed {
        logic [15:0] ether_kind;
        logic [5:0]  ip_header_bytes;
        logic        header_reject;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  payload_start;
    } tkpd_hdr_t;

endpackage

>>> hdl/tkpd_header_parser.sv
// Header parser: tracks Ethernet, VLAN, IPv4 and TCP header fields of the
// frame in progress. Depends on tkpd_pkg.
module tkpd_header_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  tkpd_pkg::tkpd_step_t step,
    output tkpd_pkg::tkpd_hdr_t  hdr
);

    logic                vlan_reg;
    logic                vlan_next;
    tkpd_pkg::tkpd_hdr_t hdr_reg;
    tkpd_pkg::tkpd_hdr_t hdr_next;
    tkpd_pkg::tkpd_hdr_t upd;
    logic                vlan_upd;
    logic [7:0]          eth_bytes;
    logic [15:0]         ip_off;
    logic [15:0]         tcp_off;
    logic [5:0]          doff_bytes;

    // Header field offsets relative to the current byte.
    assign eth_bytes  = vlan_reg ? tkpd_pkg::ETH_VLAN_BYTES : tkpd_pkg::ETH_HDR_BYTES;
    assign ip_off     = step.position - {8'd0, eth_bytes};
    assign tcp_off    = ip_off - {10'd0, hdr_reg.ip_header_bytes};
    assign doff_bytes = {step.data[7:4], 2'b00};

    // Apply the current byte to the header state.
    always_comb
    begin
        upd      = hdr_reg;
        vlan_upd = vlan_reg;
        if (step.inspect)
        begin
            if (step.position == tkpd_pkg::POS_ETYPE_HI)
                upd.ether_kind = {step.data, 8'd0};
            if (step.position == tkpd_pkg::POS_ETYPE_LO)
            begin
                upd.ether_kind = {hdr_reg.ether_kind[15:8], step.data};
                if ({hdr_reg.ether_kind[15:8], step.data} == tkpd_pkg::ETYPE_VLAN)
                    vlan_upd = 1'b1;
            end
            if (vlan_reg && step.position == tkpd_pkg::POS_VLAN_HI)
                upd.ether_kind = {step.data, 8'd0};
            if (vlan_reg && step.position == tkpd_pkg::POS_VLAN_LO)
                upd.ether_kind = {hdr_reg.ether_kind[15:8], step.data};

            if (step.position >= {8'd0, eth_bytes})
            begin
                if (ip_off == 16'd0)
                begin
                    upd.ip_header_bytes = {step.data[3:0], 2'b00};
                    if ({step.data[3:0], 2'b00} < tkpd_pkg::MIN_HDR_BYTES)
                        upd.header_reject = 1'b1;
                end
                if (ip_off == tkpd_pkg::IP_OFF_PROTO && step.data != tkpd_pkg::IP_PROTO_TCP)
                    upd.header_reject = 1'b1;
                if (ip_off >= tkpd_pkg::IP_OFF_SRC_FIRST && ip_off <= tkpd_pkg::IP_OFF_SRC_LAST)
                    upd.source_address = {hdr_reg.source_address[23:0], step.data};
                if (ip_off >= tkpd_pkg::IP_OFF_DST_FIRST && ip_off <= tkpd_pkg::IP_OFF_DST_LAST)
                    upd.destination_address = {hdr_reg.destination_address[23:0], step.data};

                // TCP header fields, once the IP header length is known.
                if (hdr_reg.ip_header_bytes >= tkpd_pkg::MIN_HDR_BYTES
                    && ip_off >= {10'd0, hdr_reg.ip_header_bytes})
                begin
                    if (tcp_off <= tkpd_pkg::TCP_OFF_SPORT_LAST)
                        upd.source_port = {hdr_reg.source_port[7:0], step.data};
                    else if (tcp_off <= tkpd_pkg::TCP_OFF_DPORT_LAST)
                        upd.destination_port = {hdr_reg.destination_port[7:0], step.data};
                    else if (tcp_off == tkpd_pkg::TCP_OFF_DOFF)
                    begin
                        if (doff_bytes < tkpd_pkg::MIN_HDR_BYTES)
                            upd.header_reject = 1'b1;
                        else
                            upd.payload_start = eth_bytes
                                + {2'd0, hdr_reg.ip_header_bytes} + {2'd0, doff_bytes};
                    end
                    else if (tcp_off == tkpd_pkg::TCP_OFF_FLAGS)
                    begin
                        if (!step.data[tkpd_pkg::TCP_PSH_BIT])
                            upd.header_reject = 1'b1;
                    end
                end
            end
        end
    end

    // Keep the update, or clear everything after the last byte.
    always_comb
    begin
        hdr_next  = hdr_reg;
        vlan_next = vlan_reg;
        if (step.advance)
        begin
            if (step.last)
            begin
                hdr_next  = '0;
                vlan_next = 1'b0;
            end
            else
            begin
                hdr_next  = upd;
                vlan_next = vlan_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= '0;
            vlan_reg <= 1'b0;
        end
        else
        begin
            hdr_reg  <= hdr_next;
            vlan_reg <= vlan_next;
        end
    end

    assign hdr = upd;

endmodule

>>> hdl/tkpd_keyword_scan.sv
// Payload scanner: shifts payload bytes up to the first zero byte through a
// six-byte window and flags any keyword. Depends on tkpd_pkg.
module tkpd_keyword_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tkpd_pkg::tkpd_step_t step,
    input  logic [7:0]           payload_start,
    output logic                 keyword_found
);

    logic [47:0] recent_reg;
    logic [47:0] recent_next;
    logic        zero_seen_reg;
    logic        zero_seen_next;
    logic        found_reg;
    logic        found_next;
    logic [47:0] recent_upd;
    logic        zero_seen_upd;
    logic        found_upd;
    logic [47:0] shifted;

    assign shifted = {recent_reg[39:0], step.data};

    // Apply the current byte to the window.
    always_comb
    begin
        recent_upd    = recent_reg;
        zero_seen_upd = zero_seen_reg;
        found_upd     = found_reg;
        if (step.inspect && payload_start != 8'd0
            && step.position >= {8'd0, payload_start} && !zero_seen_reg)
        begin
            if (step.data == 8'd0)
            begin
                zero_seen_upd = 1'b1;
                recent_upd    = '0;
            end
            else
            begin
                recent_upd = shifted;
                if (shifted[31:0] == tkpd_pkg::KW_BLOB
                    || shifted[39:0] == tkpd_pkg::KW_NONCE
                    || shifted == tkpd_pkg::KW_MINING)
                    found_upd = 1'b1;
            end
        end
    end

    // Commit, clearing after the last byte of the frame.
    always_comb
    begin
        recent_next    = recent_reg;
        zero_seen_next = zero_seen_reg;
        found_next     = found_reg;
        if (step.advance)
        begin
            recent_next    = step.last ? '0 : recent_upd;
            zero_seen_next = step.last ? 1'b0 : zero_seen_upd;
            found_next     = step.last ? 1'b0 : found_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg    <= '0;
            zero_seen_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            recent_reg    <= recent_next;
            zero_seen_reg <= zero_seen_next;
            found_reg     <= found_next;
        end
    end

    assign keyword_found = found_upd;

endmodule

>>> hdl/tcp_keyword_packet_detector_unit.sv
// Top level of the TCP keyword packet detector: input register, byte
// counter, result register. Depends on tkpd_pkg, tkpd_header_parser,
// tkpd_keyword_scan and tcp_keyword_packet_detector_unit_defines.svh.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+-------------------------------
//   frame   | frame_valid / frame_ready   | frame  (byte, end-of-frame)
//   result  | result_valid / result_ready | result (detect, addrs, ports)
//
// One byte is accepted per cycle unless a last byte is held in the input register.
// A byte waits in the input register and is applied to the frame state as it
// leaves it; the verdict for a frame is written to the result register as its
// last byte leaves the input register, later only while an earlier result waits.
// Reset clears all frame state and both valid flags.
// Only a last byte waits while an earlier result has not been taken; other
// bytes keep flowing while the result register is full.
`include "tcp_keyword_packet_detector_unit_defines.svh"

module tcp_keyword_packet_detector_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   frame_valid,
    output logic                   frame_ready,
    input  tkpd_pkg::tkpd_frame_t  frame,
    output logic                   result_valid,
    input  logic                   result_ready,
    output tkpd_pkg::tkpd_result_t result
);

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    tkpd_pkg::tkpd_frame_t  s1_data_reg;
    logic [15:0]            pos_reg;
    logic [15:0]            pos_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    tkpd_pkg::tkpd_result_t out_data_reg;
    tkpd_pkg::tkpd_result_t out_data_next;
    logic                   s1_adv;
    logic                   out_free;
    tkpd_pkg::tkpd_step_t   step;
    tkpd_pkg::tkpd_hdr_t    hdr;
    logic                   keyword_found;
    logic                   frame_ok;

    // Pipeline flow: a last byte needs a free result register.
    assign out_free    = !out_valid_reg || result_ready;
    assign s1_adv      = s1_valid_reg && (!s1_data_reg.end_of_frame || out_free);
    assign frame_ready = !s1_valid_reg || s1_adv;

    assign step.advance  = s1_adv;
    assign step.last     = s1_data_reg.end_of_frame;
    assign step.inspect  = s1_adv && (pos_reg < tkpd_pkg::MAX_FRAME_BYTES);
    assign step.position = pos_reg;
    assign step.data     = s1_data_reg.frame_byte;

    tkpd_header_parser u_header (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .hdr  (hdr)
    );

    tkpd_keyword_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .payload_start(hdr.payload_start),
        .keyword_found(keyword_found)
    );

    // Frame verdict from the state including the last byte.
    assign frame_ok = (pos_reg >= tkpd_pkg::MIN_FRAME_LAST) && !hdr.header_reject
        && (hdr.ether_kind == tkpd_pkg::ETYPE_IPV4)
        && (hdr.ip_header_bytes >= tkpd_pkg::MIN_HDR_BYTES)
        && (hdr.payload_start != 8'd0)
        && ({8'd0, hdr.payload_start} <= pos_reg) && keyword_found;

    // Input register and saturating byte counter.
    always_comb
    begin
        s1_valid_next = frame_ready ? frame_valid : s1_valid_reg;
        pos_next      = pos_reg;
        if (s1_adv)
        begin
            if (s1_data_reg.end_of_frame)
                pos_next = '0;
            else if (pos_reg != 16'hFFFF)
                pos_next = pos_reg + 16'd1;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (s1_adv && s1_data_reg.end_of_frame)
        begin
            out_valid_next                    = 1'b1;
            out_data_next.detected            = frame_ok;
            out_data_next.source_address      = frame_ok ? hdr.source_address : '0;
            out_data_next.destination_address = frame_ok ? hdr.destination_address : '0;
            out_data_next.source_port         = frame_ok ? hdr.source_port : '0;
            out_data_next.destination_port    = frame_ok ? hdr.destination_port : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (frame_ready)
            s1_data_reg <= frame;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // A rejected frame reports all-zero addresses and ports.
    `TKPD_ASSERT_NOW(a_reject_zero, result_valid && !result.detected, result.source_address == 32'd0 && result.destination_address == 32'd0 && result.source_port == 16'd0 && result.destination_port == 16'd0, "rejected frame carries nonzero fields")
    // The byte counter restarts after a last byte.
    `TKPD_ASSERT_NEXT(a_pos_restart, s1_adv && s1_data_reg.end_of_frame, pos_reg == 16'd0, "byte counter not cleared at frame end")
    // A last byte always produces a result.
    `TKPD_ASSERT_NEXT(a_result_made, s1_adv && s1_data_reg.end_of_frame, result_valid, "frame end produced no result")
    // A last byte cannot overrun a result that is still waiting.
    `TKPD_ASSERT_NOW(a_no_overrun, s1_valid_reg && s1_data_reg.end_of_frame && result_valid && !result_ready, !frame_ready && !s1_adv, "last byte advanced over a pending result")

endmodule

>>> tb/sv/tcp_keyword_packet_detector_unit_test.sv
// Self-checking testbench for tcp_keyword_packet_detector_unit: builds Ethernet
// frames byte by byte, predicts each frame verdict and checks every result.
// Depends on tkpd_pkg and the tcp_keyword_packet_detector_unit RTL.
`timescale 1ns / 1ps

module tcp_keyword_packet_detector_unit_test;

    // Frame geometry and header codes used by the verdict predictor.
    localparam int          SHORTEST_FRAME = 54;
    localparam int          ETH_PLAIN_LEN  = 14;
    localparam int          ETH_TAGGED_LEN = 18;
    localparam int          INSPECT_LIMIT  = 16383;
    localparam int          MIN_IP_HDR     = 20;
    localparam int          MIN_TCP_HDR    = 20;
    localparam logic [15:0] TYPE_VLAN      = 16'h8100;
    localparam logic [15:0] TYPE_IPV4      = 16'h0800;
    localparam logic [15:0] TYPE_IPV6      = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [31:0] WORD4          = "blob";
    localparam logic [39:0] WORD5          = "nonce";
    localparam logic [47:0] WORD6          = "mining";

    // Run shaping.
    localparam int RANDOM_BYTES  = 375;
    localparam int RANDOM_FRAMES = 4;
    localparam int TAIL_ITEMS    = 300;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 10;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_t;
    typedef enum int {WORD_NONE, WORD_BLOB, WORD_NONCE, WORD_MINING} keyword_t;

    // One pending input transaction; hold_for_drain makes the sender wait
    // until every outstanding verdict has come back.
    typedef struct {
        tkpd_pkg::tkpd_frame_t beat;
        bit                    hold_for_drain;
    } pending_byte_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   frame_valid = 1'b0;
    logic                   frame_ready;
    tkpd_pkg::tkpd_frame_t  frame = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    tkpd_pkg::tkpd_result_t result;

    pending_byte_t          byte_stream[$];
    tkpd_pkg::tkpd_result_t verdict_q[$];
    logic [7:0]             frame_bytes[$];
    fill_mode_t             hdr_fill = FILL_RANDOM;

    bit          frame_took = 1'b0;
    int          send_gap = 0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    logic [10:0] cycle_count = '0;

    // Predictor copy of the per-frame state.
    logic [15:0] pos_count = '0;
    bit          vlan_seen = 1'b0;
    logic [15:0] eth_type = '0;
    logic [5:0]  ip_hdr_len = '0;
    bit          hdr_bad = 1'b0;
    logic [31:0] src_addr = '0;
    logic [31:0] dst_addr = '0;
    logic [15:0] src_port = '0;
    logic [15:0] dst_port = '0;
    int          data_start = 0;
    bit          nul_seen = 1'b0;
    logic [47:0] tail_bytes = '0;
    bit          kw_hit = 1'b0;

    tcp_keyword_packet_detector_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clear everything the predictor tracks for one frame.
    function automatic void clear_frame_state();
        pos_count  = '0;
        vlan_seen  = 1'b0;
        eth_type   = '0;
        ip_hdr_len = '0;
        hdr_bad    = 1'b0;
        src_addr   = '0;
        dst_addr   = '0;
        src_port   = '0;
        dst_port   = '0;
        data_start = 0;
        nul_seen   = 1'b0;
        tail_bytes = '0;
        kw_hit     = 1'b0;
    endfunction

    // Apply one byte at frame position p to the header and payload state.
    function automatic void inspect_byte(input int p, input logic [7:0] b);
        int eth;
        int off;
        int t;
        int tcp_len;
        eth = vlan_seen ? ETH_TAGGED_LEN : ETH_PLAIN_LEN;
        if (p == 12) eth_type = {b, 8'h00};
        if (p == 13)
        begin
            eth_type = eth_type | {8'h00, b};
            if (eth_type == TYPE_VLAN) vlan_seen = 1'b1;
        end
        if (vlan_seen && p == 16) eth_type = {b, 8'h00};
        if (vlan_seen && p == 17) eth_type = eth_type | {8'h00, b};

        // IPv4 header, then the TCP header behind it.
        if (p >= ETH_PLAIN_LEN && p >= eth)
        begin
            off = p - eth;
            if (off == 0)
            begin
                ip_hdr_len = {b[3:0], 2'b00};
                if (ip_hdr_len < MIN_IP_HDR) hdr_bad = 1'b1;
            end
            if (off == 9 && b != PROTO_TCP) hdr_bad = 1'b1;
            if (off >= 12 && off <= 15) src_addr = {src_addr[23:0], b};
            if (off >= 16 && off <= 19) dst_addr = {dst_addr[23:0], b};
            if (ip_hdr_len >= MIN_IP_HDR && off >= int'(ip_hdr_len))
            begin
                t = off - int'(ip_hdr_len);
                if (t <= 1)
                    src_port = {src_port[7:0], b};
                else if (t <= 3)
                    dst_port = {dst_port[7:0], b};
                else if (t == 12)
                begin
                    tcp_len = int'(b[7:4]) * 4;
                    if (tcp_len < MIN_TCP_HDR) hdr_bad = 1'b1;
                    else data_start = eth + int'(ip_hdr_len) + tcp_len;
                end
                else if (t == 13)
                begin
                    if (!b[3]) hdr_bad = 1'b1;
                end
            end
        end

        // Payload scan, which stops for good at the first zero byte.
        if (data_start != 0 && p >= data_start && !nul_seen)
        begin
            if (b == 8'h00)
            begin
                nul_seen   = 1'b1;
                tail_bytes = '0;
            end
            else
            begin
                tail_bytes = {tail_bytes[39:0], b};
                if (tail_bytes[31:0] == WORD4 || tail_bytes[39:0] == WORD5 ||
                    tail_bytes == WORD6)
                    kw_hit = 1'b1;
            end
        end
    endfunction

    // Advance the predictor by one accepted byte; returns 1 with the verdict
    // when the byte ends a frame.
    function automatic bit apply_frame_byte(input logic [7:0] b, input bit last,
                                            output tkpd_pkg::tkpd_result_t verdict);
        int p;
        int len;
        bit ok;
        p = int'(pos_count);
        verdict = '0;
        if (p < INSPECT_LIMIT) inspect_byte(p, b);
        if (pos_count != 16'hFFFF) pos_count = pos_count + 16'd1;
        if (!last) return 1'b0;
        len = p + 1;
        ok = len >= SHORTEST_FRAME && !hdr_bad && eth_type == TYPE_IPV4 &&
             ip_hdr_len >= MIN_IP_HDR && data_start != 0 && data_start < len && kw_hit;
        if (ok)
        begin
            verdict.detected            = 1'b1;
            verdict.source_address      = src_addr;
            verdict.destination_address = dst_addr;
            verdict.source_port         = src_port;
            verdict.destination_port    = dst_port;
        end
        clear_frame_state();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("MISMATCH result %0d %s: got %0h expected %0h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Header byte that follows the current fill mode.
    function automatic logic [7:0] fill_byte();
        case (hdr_fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Start a new frame: Ethernet, optional VLAN tag, IPv4 and TCP headers.
    function automatic void build_tcp_frame(input bit vlan, input int ihl, input int doff,
                                            input bit psh, input logic [7:0] proto,
                                            input logic [15:0] etype);
        logic [7:0] flags;
        logic [7:0] doff_byte;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(fill_byte());
        if (vlan)
        begin
            frame_bytes.push_back(TYPE_VLAN[15:8]);
            frame_bytes.push_back(TYPE_VLAN[7:0]);
            repeat (2) frame_bytes.push_back(fill_byte());
        end
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        frame_bytes.push_back({4'h4, 4'(ihl)});
        repeat (8) frame_bytes.push_back(fill_byte());
        frame_bytes.push_back(proto);
        repeat (10) frame_bytes.push_back(fill_byte());
        if (ihl > 5) repeat (ihl * 4 - 20) frame_bytes.push_back(fill_byte());
        repeat (12) frame_bytes.push_back(fill_byte());
        doff_byte      = fill_byte();
        doff_byte[7:4] = 4'(doff);
        frame_bytes.push_back(doff_byte);
        flags = fill_byte();
        flags[3] = psh;
        frame_bytes.push_back(flags);
        repeat (6) frame_bytes.push_back(fill_byte());
        if (doff > 5) repeat (doff * 4 - 20) frame_bytes.push_back(fill_byte());
    endfunction

    // Nonzero payload text, biased toward keyword letters to provoke near misses.
    function automatic void add_text(input int n);
        string letters;
        letters = "bolnceimgx";
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0)
                frame_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
            else
                frame_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    function automatic void add_word(input keyword_t w);
        string text;
        case (w)
            WORD_BLOB:   text = "blob";
            WORD_NONCE:  text = "nonce";
            WORD_MINING: text = "mining";
            default:     text = "";
        endcase
        for (int i = 0; i < text.len(); i++) frame_bytes.push_back(text[i]);
    endfunction

    // Queue the built frame as input transactions, end flag on its last byte.
    function automatic void ship_frame(input bit drain_first);
        pending_byte_t entry;
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            entry.beat.frame_byte   = frame_bytes[i];
            entry.beat.end_of_frame = (i == frame_bytes.size() - 1);
            entry.hold_for_drain    = drain_first && i == 0;
            byte_stream.push_back(entry);
        end
    endfunction

    // Stimulus, reset and end of run.
    initial
    begin
        int         rand_bytes;
        int         rand_frames;
        int         ihl;
        int         doff;
        int         fault;
        bit         vlan;
        bit         psh;
        logic [7:0] proto;
        logic [15:0] etype;

        // Detected frames with header fields at both extremes.
        hdr_fill = FILL_ZERO;
        build_tcp_frame(1'b0, 5, 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_text(3);
        add_word(WORD_BLOB);
        ship_frame(1'b0);
        hdr_fill = FILL_ONES;
        build_tcp_frame(1'b1, 5, 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_NONCE);
        add_text(2);
        ship_frame(1'b0);
        hdr_fill = FILL_RANDOM;
        build_tcp_frame(1'b0, 15, 15, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_text(1);
        add_word(WORD_MINING);
        ship_frame(1'b1);

        // A keyword that starts in the TCP options does not count.
        build_tcp_frame(1'b0, 5, 6, 1'b1, PROTO_TCP, TYPE_IPV4);
        frame_bytes[frame_bytes.size() - 2] = "b";
        frame_bytes[frame_bytes.size() - 1] = "l";
        frame_bytes.push_back("o");
        frame_bytes.push_back("b");
        add_text(2);
        ship_frame(1'b0);

        // Short frames: one byte short of the minimum, header only, single bytes.
        build_tcp_frame(1'b0, 5, 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_BLOB);
        while (frame_bytes.size() > SHORTEST_FRAME - 1) void'(frame_bytes.pop_back());
        ship_frame(1'b0);
        build_tcp_frame(1'b0, 5, 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        ship_frame(1'b0);
        repeat (4)
        begin
            frame_bytes.delete();
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            ship_frame(1'b0);
        end

        // Header faults, each with a keyword present.
        build_tcp_frame(1'b0, 5, $urandom_range(0, 4), 1'b1, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_NONCE);
        ship_frame(1'b0);
        build_tcp_frame(1'b0, $urandom_range(0, 4), 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_BLOB);
        ship_frame(1'b0);
        build_tcp_frame(1'b1, 5, 5, 1'b0, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_MINING);
        ship_frame(1'b0);
        build_tcp_frame(1'b0, 5, 5, 1'b1, PROTO_UDP, TYPE_IPV4);
        add_word(WORD_BLOB);
        ship_frame(1'b0);
        build_tcp_frame(1'b0, 5, 5, 1'b1, PROTO_TCP, TYPE_IPV6);
        add_word(WORD_NONCE);
        ship_frame(1'b0);
        build_tcp_frame(1'b1, 5, 5, 1'b1, PROTO_TCP, TYPE_VLAN);
        add_word(WORD_BLOB);
        ship_frame(1'b0);

        // Payload start lies beyond the end of the frame.
        build_tcp_frame(1'b0, 5, 15, 1'b1, PROTO_TCP, TYPE_IPV4);
        repeat (10) void'(frame_bytes.pop_back());
        ship_frame(1'b0);

        // Zero byte ahead of the keyword, then behind it.
        build_tcp_frame(1'b0, 6, 5, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_text(2);
        frame_bytes.push_back(8'h00);
        add_word(WORD_BLOB);
        ship_frame(1'b0);
        build_tcp_frame(1'b1, 5, 7, 1'b1, PROTO_TCP, TYPE_IPV4);
        add_word(WORD_MINING);
        frame_bytes.push_back(8'h00);
        add_text(3);
        ship_frame(1'b1);

        // Random frames: mostly well formed, the rest broken or garbage.
        rand_bytes  = 0;
        rand_frames = 0;
        while (rand_bytes < RANDOM_BYTES || rand_frames < RANDOM_FRAMES)
        begin
            ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            doff  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            vlan  = ($urandom_range(0, 3) == 0);
            psh   = 1'b1;
            proto = PROTO_TCP;
            etype = TYPE_IPV4;
            fault = $urandom_range(0, 19);
            case (fault)
                0: psh = 1'b0;
                1: doff = $urandom_range(0, 4);
                2: ihl = $urandom_range(0, 4);
                3: proto = 8'($urandom_range(0, 255));
                4: etype = 16'($urandom);
                5:
                begin
                    vlan  = 1'b1;
                    etype = TYPE_VLAN;
                end
                default: ;
            endcase
            build_tcp_frame(vlan, ihl, doff, psh, proto, etype);
            add_text($urandom_range(0, 12));
            if ($urandom_range(0, 9) < 7) add_word(keyword_t'($urandom_range(1, 3)));
            if ($urandom_range(0, 4) == 0) frame_bytes.push_back(8'h00);
            add_text($urandom_range(0, 12));
            if (fault == 6)
                repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
            if (fault == 7)
            begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            rand_bytes += frame_bytes.size();
            rand_frames++;
            ship_frame(rand_frames % 10 == 9);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last input transaction, then for the last verdict.
        while (byte_stream.size() > 0 || frame_valid) @(posedge clk);
        while (verdict_q.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Frame driver: presents queued bytes, with random gaps between them.
    always @(negedge clk)
    begin
        if (rst_n && (!frame_valid || frame_took))
        begin
            if (send_gap > 0)
            begin
                send_gap    <= send_gap - 1;
                frame_valid <= 1'b0;
            end
            else if (byte_stream.size() > 0 &&
                     !(byte_stream[0].hold_for_drain && verdict_q.size() > 0))
            begin
                frame       <= byte_stream[0].beat;
                frame_valid <= 1'b1;
                if (byte_stream.size() > TAIL_ITEMS && !cycle_count[9] &&
                    $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 8);
                void'(byte_stream.pop_front());
            end
            else
            begin
                frame_valid <= 1'b0;
            end
        end
    end

    // Result sink: stalls in random bursts, none near the end of the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_ready <= 1'b0;
            end
            else if (byte_stream.size() > TAIL_ITEMS && (cycle_count[8] ^ cycle_count[10]) &&
                     $urandom_range(0, 5) == 0)
            begin
                hold_left    <= $urandom_range(0, 7);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted byte and checks each accepted result.
    always @(posedge clk)
    begin
        tkpd_pkg::tkpd_result_t verdict;
        tkpd_pkg::tkpd_result_t want;
        bit                     has_verdict;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 11'd1;
            frame_took  <= frame_valid && frame_ready;
            if (frame_valid && frame_ready)
            begin
                has_verdict = apply_frame_byte(frame.frame_byte, frame.end_of_frame, verdict);
                if (has_verdict) verdict_q.push_back(verdict);
            end
            if (result_valid && result_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("unexpected result transaction", 48'(result.detected), '0);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.detected !== want.detected)
                        report_mismatch("detected", 48'(result.detected), 48'(want.detected));
                    if (result.source_address !== want.source_address)
                        report_mismatch("source_address", 48'(result.source_address),
                                        48'(want.source_address));
                    if (result.destination_address !== want.destination_address)
                        report_mismatch("destination_address",
                                        48'(result.destination_address),
                                        48'(want.destination_address));
                    if (result.source_port !== want.source_port)
                        report_mismatch("source_port", 48'(result.source_port),
                                        48'(want.source_port));
                    if (result.destination_port !== want.destination_port)
                        report_mismatch("destination_port", 48'(result.destination_port),
                                        48'(want.destination_port));
                end
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_valid && frame_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

>>> tcp_keyword_packet_detector_unit.f
+incdir+hdl
hdl/tkpd_pkg.sv
hdl/tkpd_header_parser.sv
hdl/tkpd_keyword_scan.sv
hdl/tcp_keyword_packet_detector_unit.sv
tb/sv/tcp_keyword_packet_detector_unit_test.sv
